/* hdl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg - shared types and constants for the sorted list block
// Beat formats, operation and status codes, and the compare result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sli_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 5;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_REMOVE    = 2'd1,
        OP_DUMP_ASC  = 2'd2,
        OP_DUMP_DESC = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [VALUE_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
        logic                      last;
    } res_beat_t;

    typedef struct packed {
        logic le;
        logic eq;
    } cmp_t;

endpackage

/* hdl/sli_cmp.sv */
// ----------------------------------------------------------------------------
// sli_cmp - shared signed compare unit
// Gives a <= b (signed) and a == b for the list sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sli_cmp (
    input  logic signed [sli_pkg::VALUE_W-1:0] a,
    input  logic signed [sli_pkg::VALUE_W-1:0] b,
    output sli_pkg::cmp_t                      result
);
    import sli_pkg::*;

    assign result.le = (a <= b);
    assign result.eq = (a == b);

endmodule

/* hdl/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove - ascending list of signed values, CAPACITY deep
// Insert: reads entries from the top one down to the first one at or below the
// value, then places it; remove reads every entry; full insert, empty remove or
// dump go straight to the emit step. Dump: read, latch and load steps per beat.
// The store has one read port; result stalls hold the sequencer in its emit step.
// Async reset empties the list; store contents stay undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_insert_remove #(
    parameter int CAPACITY = sli_pkg::DEFAULT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sli_pkg::cmd_beat_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output sli_pkg::res_beat_t res
);
    import sli_pkg::*;

    // Entry address and count widths; the count must hold CAPACITY itself.
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PLACE,
        S_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     found_reg, found_next;
    res_beat_t                pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    res_beat_t                out_reg, out_next;

    // Entry store: one write and one registered read per cycle.
    logic [VALUE_W-1:0]       mem [CAPACITY];
    logic [VALUE_W-1:0]       rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [VALUE_W-1:0]       mem_wdata;

    logic [CNT_W-1:0]         idx_inc, idx_dec, last_idx, desc_idx;
    logic                     out_free;
    cmp_t                     cmp;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign last_idx = count_reg - CNT_W'(1);
    assign desc_idx = last_idx - idx_reg;

    // Output register: a new beat may load when the slot is empty or draining.
    assign out_free  = !out_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Dumps descending walk the store from the top; everything else from idx.
    assign rd_addr = (op_reg == OP_DUMP_DESC) ? desc_idx[AW-1:0] : idx_reg[AW-1:0];

    // One compare unit serves both the insert scan and the remove search.
    sli_cmp u_cmp (
        .a      ($signed(rd_data_reg)),
        .b      (val_reg),
        .result (cmp)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = val_reg;

        // Drop the beat once the far side has taken it.
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next                = cmd.operation;
                    val_next               = cmd.value;
                    found_next             = 1'b0;
                    pend_next.entry_value  = '0;
                    pend_next.entry_count  = COUNT_W'(count_reg);
                    pend_next.last         = 1'b1;
                    pend_next.status       = ST_OK;
                    unique case (cmd.operation) inside
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                pend_next.status = ST_FULL;
                                state_next       = S_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                // Scan downwards from the top entry.
                                idx_next   = last_idx;
                                state_next = S_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_NOT_FOUND;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        OP_DUMP_ASC, OP_DUMP_DESC:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                // Read data lands in rd_data_reg at this edge.
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (op_reg) inside
                    OP_INSERT:
                    begin
                        if (cmp.le)
                        begin
                            // New value sits just above this entry.
                            idx_next   = idx_inc;
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            // Shift this entry up one place and keep scanning.
                            mem_we    = 1'b1;
                            mem_waddr = idx_inc[AW-1:0];
                            mem_wdata = rd_data_reg;
                            if (idx_reg == '0)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                idx_next   = idx_dec;
                                state_next = S_READ;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        // After the first match, close the gap one entry at a time.
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_dec[AW-1:0];
                            mem_wdata = rd_data_reg;
                        end
                        found_next = found_reg || cmp.eq;
                        if (idx_reg == last_idx)
                        begin
                            if (found_reg || cmp.eq)
                            begin
                                count_next            = last_idx;
                                pend_next.status      = ST_OK;
                                pend_next.entry_count = COUNT_W'(last_idx);
                            end
                            else
                            begin
                                pend_next.status      = ST_NOT_FOUND;
                            end
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_READ;
                        end
                    end
                    OP_DUMP_ASC, OP_DUMP_DESC:
                    begin
                        pend_next.entry_value = $signed(rd_data_reg);
                        pend_next.status      = ST_OK;
                        pend_next.entry_count = COUNT_W'(count_reg);
                        pend_next.last        = (idx_reg == last_idx);
                        state_next            = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_PLACE:
            begin
                mem_we                = 1'b1;
                mem_waddr             = idx_reg[AW-1:0];
                mem_wdata             = val_reg;
                count_next            = count_reg + CNT_W'(1);
                pend_next.status      = ST_OK;
                pend_next.entry_count = COUNT_W'(count_reg + CNT_W'(1));
                state_next            = S_EMIT;
            end

            S_EMIT:
            begin
                // Hold here until the output register can take the beat.
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    if (pend_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            op_reg        <= OP_INSERT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The count moves by one at most per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // An accepted command keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted while idle on the following cycle");

    // The count only changes while a command is being worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed while idle");

endmodule
